@@ rtl/intc_pkg.sv @@
package intc_pkg;

  localparam int NUM_IRQ = 64;
  localparam int NUM_SGI = 16;
  localparam int IRQ_AW = $clog2(NUM_IRQ);
  localparam int CNT_W = IRQ_AW + 1;

  localparam logic [9:0] SPURIOUS = 10'h3FF;
  localparam logic [8:0] IDLE_PRIO = 9'h100;

  localparam logic [1:0] CFG_DIST_ENABLE = 2'd0;
  localparam logic [1:0] CFG_CPU_ENABLE = 2'd1;
  localparam logic [1:0] CFG_PRIORITY_MASK = 2'd2;

  localparam logic [3:0] CMD_LINE = 4'd0;
  localparam logic [3:0] CMD_SET_EN = 4'd1;
  localparam logic [3:0] CMD_CLR_EN = 4'd2;
  localparam logic [3:0] CMD_SET_PEND = 4'd3;
  localparam logic [3:0] CMD_CLR_PEND = 4'd4;
  localparam logic [3:0] CMD_SET_PRIO = 4'd5;
  localparam logic [3:0] CMD_SET_TRIG = 4'd6;
  localparam logic [3:0] CMD_ACK = 4'd7;
  localparam logic [3:0] CMD_EOI = 4'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_A,
    ST_EXEC,
    ST_EOI_RD,
    ST_EOI_PRIO,
    ST_WALK,
    ST_SCAN_B,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic scan;
    logic exec;
    logic eoi_rd;
    logic eoi_prio;
    logic walk;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_last;
    logic eoi_go;
    logic eoi_cur;
    logic walk_ok;
    logic walk_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/intc_if.sv @@
interface intc_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [9:0] irq_id;
  logic [7:0] value;
  modport source (output valid, cmd, irq_id, value, input ready);
  modport sink (input valid, cmd, irq_id, value, output ready);
endinterface

interface intc_out_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [9:0] pending_id;
  logic [9:0] ack_id;
  logic [8:0] running_prio;
  modport source (output valid, irq_line, pending_id, ack_id, running_prio, input ready);
  modport sink (input valid, irq_line, pending_id, ack_id, running_prio, output ready);
endinterface

@@ rtl/intc_ram.sv @@
module intc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/intc_ctrl.sv @@
module intc_ctrl
  import intc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN_A;
      ST_SCAN_A: if (sts.scan_last) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.eoi_go) state_nxt = ST_EOI_RD;
        else state_nxt = ST_SCAN_B;
      end
      ST_EOI_RD: begin
        if (sts.eoi_cur) state_nxt = ST_EOI_PRIO;
        else if (sts.walk_ok) state_nxt = ST_WALK;
        else state_nxt = ST_SCAN_B;
      end
      ST_EOI_PRIO: state_nxt = ST_SCAN_B;
      ST_WALK: if (sts.walk_done) state_nxt = ST_SCAN_B;
      ST_SCAN_B: if (sts.scan_last) state_nxt = ST_OUT;
      ST_OUT: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: cmd.take = 1'b1;
      ST_SCAN_A: cmd.scan = 1'b1;
      ST_EXEC: cmd.exec = 1'b1;
      ST_EOI_RD: cmd.eoi_rd = 1'b1;
      ST_EOI_PRIO: cmd.eoi_prio = 1'b1;
      ST_WALK: cmd.walk = 1'b1;
      ST_SCAN_B: cmd.scan = 1'b1;
      ST_OUT: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/intc_dp.sv @@
module intc_dp
  import intc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_fire,
  input  logic [3:0] in_cmd,
  input  logic [9:0] in_irq_id,
  input  logic [7:0] in_value,
  input  logic       out_ready,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       out_valid,
  output logic       out_irq_line,
  output logic [9:0] out_pending_id,
  output logic [9:0] out_ack_id,
  output logic [8:0] out_running_prio
);

  localparam logic [NUM_IRQ-1:0] EN_RESET = {{(NUM_IRQ-NUM_SGI){1'b0}}, {NUM_SGI{1'b1}}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_IRQ);
  localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(NUM_IRQ - 1);

  logic             dist_en_r, cpu_en_r;
  logic [7:0]       mask_r;
  logic [3:0]       cmd_r;
  logic [9:0]       id_r;
  logic [7:0]       val_r;
  logic [NUM_IRQ-1:0] en_r, pend_r, lvl_r, edge_r;
  logic [9:0]       cur_r;
  logic [8:0]       cprio_r;
  logic [CNT_W-1:0] cnt_r, clr_r, wn_r;
  logic [8:0]       bp_r;
  logic [9:0]       best_r;
  logic [9:0]       it_r, pid_r, ack_r;
  logic             out_valid_r, out_line_r;
  logic [9:0]       out_pend_r, out_ack_r;
  logic [8:0]       out_prio_r;

  logic [7:0]        prio_rd;
  logic [9:0]        prev_rd;
  logic [IRQ_AW-1:0] prio_raddr, prio_waddr, prev_raddr, prev_waddr;
  logic              prio_we, prev_we;
  logic [7:0]        prio_wdata;
  logic [9:0]        prev_wdata;

  logic              id_ok, fwd_en, win, ack_ok, scan_hit, walk_hit;
  logic [IRQ_AW-1:0] ix, sidx;
  logic [CNT_W-1:0]  cnt_m1;

  assign id_ok = (id_r < 10'(NUM_IRQ));
  assign ix = id_r[IRQ_AW-1:0];
  assign fwd_en = dist_en_r && cpu_en_r;
  assign win = fwd_en && (bp_r < {1'b0, mask_r});
  assign ack_ok = win && (bp_r < cprio_r);
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign sidx = cnt_m1[IRQ_AW-1:0];
  assign scan_hit = (cnt_r != '0) && en_r[sidx] && pend_r[sidx] && ({1'b0, prio_rd} < bp_r);
  assign walk_hit = (prev_rd == id_r);

  assign sts.clr_done = (clr_r == IDX_LAST);
  assign sts.scan_last = (cnt_r == CNT_LAST);
  assign sts.eoi_go = (cmd_r == CMD_EOI) && (cur_r != SPURIOUS) && id_ok;
  assign sts.eoi_cur = (id_r == cur_r);
  assign sts.walk_ok = (cur_r < 10'(NUM_IRQ));
  assign sts.walk_done = (prev_rd == SPURIOUS) || walk_hit || (prev_rd >= 10'(NUM_IRQ)) ||
                         (wn_r == IDX_LAST);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    prio_raddr = '0;
    prev_raddr = '0;
    prio_we = 1'b0;
    prio_waddr = '0;
    prio_wdata = '0;
    prev_we = 1'b0;
    prev_waddr = '0;
    prev_wdata = SPURIOUS;
    if (cmd.scan) prio_raddr = cnt_r[IRQ_AW-1:0];
    if (cmd.eoi_rd) prio_raddr = prev_rd[IRQ_AW-1:0];
    if (cmd.exec) prev_raddr = ix;
    if (cmd.eoi_rd) prev_raddr = cur_r[IRQ_AW-1:0];
    if (cmd.walk) prev_raddr = prev_rd[IRQ_AW-1:0];
    if (cmd.clear) begin
      prio_we = 1'b1;
      prio_waddr = clr_r[IRQ_AW-1:0];
      prev_we = 1'b1;
      prev_waddr = clr_r[IRQ_AW-1:0];
    end
    if (cmd.exec && cmd_r == CMD_SET_PRIO && id_ok) begin
      prio_we = 1'b1;
      prio_waddr = ix;
      prio_wdata = val_r;
    end
    if (cmd.exec && cmd_r == CMD_ACK && ack_ok) begin
      prev_we = 1'b1;
      prev_waddr = best_r[IRQ_AW-1:0];
      prev_wdata = cur_r;
    end
    if (cmd.walk && walk_hit) begin
      prev_we = 1'b1;
      prev_waddr = it_r[IRQ_AW-1:0];
      prev_wdata = pid_r;
    end
  end

  intc_ram #(.WIDTH(8), .DEPTH(NUM_IRQ)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (prio_waddr),
    .wdata (prio_wdata),
    .raddr (prio_raddr),
    .rdata (prio_rd)
  );

  intc_ram #(.WIDTH(10), .DEPTH(NUM_IRQ)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_en_r <= 1'b0;
      cpu_en_r <= 1'b0;
      mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIST_ENABLE: dist_en_r <= cfg_data[0];
        CFG_CPU_ENABLE: cpu_en_r <= cfg_data[0];
        CFG_PRIORITY_MASK: mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      id_r <= in_irq_id;
      val_r <= in_value;
    end
    if (cmd.scan) begin
      if (cnt_r == '0) begin
        bp_r <= IDLE_PRIO;
        best_r <= SPURIOUS;
      end else if (scan_hit) begin
        bp_r <= {1'b0, prio_rd};
        best_r <= 10'(sidx);
      end
    end
    if (cmd.eoi_rd) begin
      pid_r <= prev_rd;
      it_r <= cur_r;
    end
    if (cmd.walk) it_r <= prev_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      clr_r <= '0;
      wn_r <= '0;
    end else begin
      cnt_r <= (cmd.scan && !sts.scan_last) ? cnt_r + CNT_W'(1) : '0;
      if (cmd.clear) clr_r <= clr_r + CNT_W'(1);
      wn_r <= cmd.walk ? wn_r + CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= EN_RESET;
      pend_r <= '0;
      lvl_r <= '0;
      edge_r <= '1;
      cur_r <= SPURIOUS;
      cprio_r <= IDLE_PRIO;
      ack_r <= SPURIOUS;
    end else begin
      if (in_fire) ack_r <= SPURIOUS;
      if (cmd.exec) begin
        case (cmd_r)
          CMD_LINE: begin
            if (id_ok) begin
              if (edge_r[ix]) begin
                if (val_r[0] && !lvl_r[ix]) pend_r[ix] <= 1'b1;
              end else begin
                pend_r[ix] <= val_r[0];
              end
              lvl_r[ix] <= val_r[0];
            end
          end
          CMD_SET_EN: begin
            if (id_ok) begin
              en_r[ix] <= 1'b1;
              if (!edge_r[ix] && lvl_r[ix]) pend_r[ix] <= 1'b1;
            end
          end
          CMD_CLR_EN: if (id_ok && id_r >= 10'(NUM_SGI)) en_r[ix] <= 1'b0;
          CMD_SET_PEND: if (id_ok) pend_r[ix] <= 1'b1;
          CMD_CLR_PEND: if (id_ok) pend_r[ix] <= 1'b0;
          CMD_SET_TRIG: if (id_ok) edge_r[ix] <= val_r[0];
          CMD_ACK: begin
            if (ack_ok) begin
              pend_r[best_r[IRQ_AW-1:0]] <= 1'b0;
              cur_r <= best_r;
              cprio_r <= bp_r;
              ack_r <= best_r;
            end
          end
          default: ;
        endcase
      end
      if (cmd.eoi_rd && sts.eoi_cur) cur_r <= prev_rd;
      if (cmd.eoi_prio) cprio_r <= (cur_r < 10'(NUM_IRQ)) ? {1'b0, prio_rd} : IDLE_PRIO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_line_r <= ack_ok;
      out_pend_r <= win ? best_r : SPURIOUS;
      out_ack_r <= ack_r;
      out_prio_r <= cprio_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_irq_line = out_line_r;
  assign out_pending_id = out_pend_r;
  assign out_ack_id = out_ack_r;
  assign out_running_prio = out_prio_r;

  // The running priority follows the current interrupt in the cycle after it, on an
  // end of interrupt of the current interrupt.
  a_idle_pair: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.eoi_prio |-> (cur_r == SPURIOUS) == (cprio_r == IDLE_PRIO))
    else $error("running priority and current interrupt disagree");

  a_line_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_line_r |-> out_pend_r != SPURIOUS)
    else $error("irq line raised without a pending winner");

  a_ack_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ack_r != SPURIOUS |-> out_prio_r != IDLE_PRIO)
    else $error("acknowledged interrupt without running priority");

endmodule

@@ rtl/interrupt_controller_cpu_interface_core.sv @@
// Single-CPU interrupt controller with the CPU interface: one result word per
// command word. After reset a clearing pass initializes the priority and
// active-chain memories before the first word is accepted. Each word passes
// the accept state, a priority scan through the single read port of the
// priority memory, the command state, a second scan and the output state.
// An end of interrupt of the current interrupt adds a read state and a
// priority state; any other in-range end of interrupt while one is active adds a
// read state plus a walk of the active chain, one link per cycle. A stalled
// output word holds the block in its output state.
module interrupt_controller_cpu_interface_core
  import intc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  intc_in_if.sink    in_ch,
  intc_out_if.source out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_fire;

  assign in_ch.ready = cmd.take;
  assign in_fire = in_ch.valid && cmd.take;

  intc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  intc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_fire          (in_fire),
    .in_cmd           (in_ch.cmd),
    .in_irq_id        (in_ch.irq_id),
    .in_value         (in_ch.value),
    .out_ready        (out_ch.ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_irq_line     (out_ch.irq_line),
    .out_pending_id   (out_ch.pending_id),
    .out_ack_id       (out_ch.ack_id),
    .out_running_prio (out_ch.running_prio)
  );

endmodule

@@ bench/tb_interrupt_controller_cpu_interface_core.sv @@
module tb_interrupt_controller_cpu_interface_core;
  import intc_pkg::*;

  typedef struct {
    bit       irq_line;
    bit [9:0] pending_id;
    bit [9:0] ack_id;
    bit [8:0] running_prio;
  } intc_result_t;

  class intc_scoreboard;
    bit           en_bit[NUM_IRQ];
    bit           pend_bit[NUM_IRQ];
    bit           lvl_bit[NUM_IRQ];
    bit           edge_bit[NUM_IRQ];
    bit [7:0]     prio[NUM_IRQ];
    bit [9:0]     prev_act[NUM_IRQ];
    bit [9:0]     cur_irq;
    bit [8:0]     cur_prio;
    bit [9:0]     best_id;
    bit           line;
    bit           dist_en;
    bit           cpu_en;
    bit [7:0]     mask;
    intc_result_t expected[$];
    int           errors;

    function new();
      for (int i = 0; i < NUM_IRQ; i++) begin
        en_bit[i] = (i < NUM_SGI);
        pend_bit[i] = 0;
        lvl_bit[i] = 0;
        edge_bit[i] = 1;
        prio[i] = 0;
        prev_act[i] = SPURIOUS;
      end
      cur_irq = SPURIOUS;
      cur_prio = IDLE_PRIO;
      best_id = SPURIOUS;
      line = 0;
      dist_en = 0;
      cpu_en = 0;
      mask = 0;
      errors = 0;
    endfunction

    function void rescan();
      bit [9:0] best;
      bit [8:0] bp;
      best = SPURIOUS;
      bp = IDLE_PRIO;
      best_id = SPURIOUS;
      line = 0;
      if (dist_en && cpu_en) begin
        for (int i = 0; i < NUM_IRQ; i++) begin
          if (en_bit[i] && pend_bit[i] && prio[i] < bp) begin
            bp = prio[i];
            best = i;
          end
        end
        if (bp < mask) begin
          best_id = best;
          if (bp < cur_prio) line = 1;
        end
      end
    endfunction

    function void write_reg(bit [1:0] idx, bit [7:0] d);
      case (idx)
        CFG_DIST_ENABLE: dist_en = d[0];
        CFG_CPU_ENABLE: cpu_en = d[0];
        CFG_PRIORITY_MASK: mask = d;
        default: return;
      endcase
      rescan();
    endfunction

    function void end_irq(bit [9:0] id);
      bit [9:0] it;
      if (cur_irq == SPURIOUS || id >= NUM_IRQ) return;
      if (id == cur_irq) begin
        cur_irq = prev_act[id];
        cur_prio = (cur_irq < NUM_IRQ) ? {1'b0, prio[cur_irq]} : IDLE_PRIO;
        return;
      end
      it = cur_irq;
      for (int n = 0; n < NUM_IRQ; n++) begin
        if (it >= NUM_IRQ || prev_act[it] == SPURIOUS) break;
        if (prev_act[it] == id) begin
          prev_act[it] = prev_act[id];
          break;
        end
        it = prev_act[it];
      end
    endfunction

    function void note_word(bit [3:0] c, bit [9:0] id, bit [7:0] v);
      intc_result_t r;
      bit [9:0] ack;
      bit ok;
      ack = SPURIOUS;
      ok = id < NUM_IRQ;
      rescan();
      case (c)
        CMD_LINE: if (ok) begin
          if (edge_bit[id]) begin
            if (v[0] && !lvl_bit[id]) pend_bit[id] = 1;
          end else begin
            pend_bit[id] = v[0];
          end
          lvl_bit[id] = v[0];
        end
        CMD_SET_EN: if (ok) begin
          en_bit[id] = 1;
          if (!edge_bit[id] && lvl_bit[id]) pend_bit[id] = 1;
        end
        CMD_CLR_EN: if (ok && id >= NUM_SGI) en_bit[id] = 0;
        CMD_SET_PEND: if (ok) pend_bit[id] = 1;
        CMD_CLR_PEND: if (ok) pend_bit[id] = 0;
        CMD_SET_PRIO: if (ok) prio[id] = v;
        CMD_SET_TRIG: if (ok) edge_bit[id] = v[0];
        CMD_ACK: begin
          if (best_id < NUM_IRQ && prio[best_id] < cur_prio) begin
            ack = best_id;
            pend_bit[ack] = 0;
            prev_act[ack] = cur_irq;
            cur_irq = ack;
            cur_prio = prio[ack];
          end
        end
        CMD_EOI: end_irq(id);
        default: ;
      endcase
      rescan();
      r.irq_line = line;
      r.pending_id = best_id;
      r.ack_id = ack;
      r.running_prio = cur_prio;
      expected.push_back(r);
    endfunction

    function void check_word(intc_result_t got);
      intc_result_t e;
      if (expected.size() == 0) begin
        $error("Result word with no expectation pending.");
        errors++;
        return;
      end
      e = expected.pop_front();
      if (got.irq_line !== e.irq_line) begin
        $error("irq_line expected %0d actual %0d", e.irq_line, got.irq_line);
        errors++;
      end
      if (got.pending_id !== e.pending_id) begin
        $error("pending_id expected %0d actual %0d", e.pending_id, got.pending_id);
        errors++;
      end
      if (got.ack_id !== e.ack_id) begin
        $error("ack_id expected %0d actual %0d", e.ack_id, got.ack_id);
        errors++;
      end
      if (got.running_prio !== e.running_prio) begin
        $error("running_prio expected %0d actual %0d", e.running_prio, got.running_prio);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 4000000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         hold_left;
  bit         quiet;
  int         cycles;

  intc_in_if in_ch();
  intc_out_if out_ch();
  intc_scoreboard sb = new();

  interrupt_controller_cpu_interface_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_word(in_ch.cmd, in_ch.irq_id, in_ch.value);
  end

  always @(posedge clk) begin
    intc_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.irq_line = out_ch.irq_line;
      got.pending_id = out_ch.pending_id;
      got.ack_id = out_ch.ack_id;
      got.running_prio = out_ch.running_prio;
      sb.check_word(got);
    end
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 0;
        hold_left--;
      end else begin
        out_ch.ready = quiet || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  task automatic write_reg(bit [1:0] idx, bit [7:0] d);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_word(bit [3:0] c, bit [9:0] id, bit [7:0] v);
    if (!quiet && $urandom_range(0, 99) < 31) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.cmd = c;
    in_ch.irq_id = id;
    in_ch.value = v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic random_word();
    int r;
    bit [9:0] id;
    bit [7:0] v;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, NUM_IRQ - 1);
    v = $urandom_range(0, 255);
    if (r < 12) send_word(CMD_ACK, id, v);
    else if (r < 22) begin
      if ($urandom_range(0, 9) < 6 && sb.cur_irq != SPURIOUS) id = sb.cur_irq;
      send_word(CMD_EOI, id, v);
    end
    else if (r < 40) send_word(CMD_LINE, id, v);
    else if (r < 50) send_word(CMD_SET_EN, id, v);
    else if (r < 56) send_word(CMD_CLR_EN, id, v);
    else if (r < 66) send_word(CMD_SET_PEND, id, v);
    else if (r < 72) send_word(CMD_CLR_PEND, id, v);
    else if (r < 84) send_word(CMD_SET_PRIO, id, v);
    else if (r < 90) send_word(CMD_SET_TRIG, id, v);
    else if (r < 95) send_word($urandom_range(0, 8), $urandom_range(0, 1023), v);
    else send_word($urandom_range(9, 15), id, v);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.cmd = 0;
    in_ch.irq_id = 0;
    in_ch.value = 0;
    hold_left = 0;
    quiet = 0;
    cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed words with the block disabled, then enabled with an open mask.
    send_word(CMD_SET_PEND, 10'd3, 8'd0);
    send_word(CMD_ACK, 10'd0, 8'd0);
    drain();
    write_reg(CFG_DIST_ENABLE, 8'd1);
    write_reg(CFG_CPU_ENABLE, 8'd1);
    write_reg(CFG_PRIORITY_MASK, 8'hFF);
    send_word(CMD_SET_PRIO, 10'd20, 8'h00);
    send_word(CMD_SET_PRIO, 10'd21, 8'hFF);
    send_word(CMD_SET_PRIO, 10'd63, 8'h40);
    send_word(CMD_SET_EN, 10'd20, 8'd0);
    send_word(CMD_LINE, 10'd20, 8'd1);
    send_word(CMD_LINE, 10'd20, 8'd1);
    send_word(CMD_ACK, 10'd1023, 8'd0);
    send_word(CMD_SET_TRIG, 10'd63, 8'd0);
    send_word(CMD_LINE, 10'd63, 8'd1);
    send_word(CMD_SET_EN, 10'd63, 8'd0);
    send_word(CMD_SET_PRIO, 10'd5, 8'h10);
    send_word(CMD_SET_PEND, 10'd5, 8'd0);
    send_word(CMD_ACK, 10'd0, 8'd0);
    send_word(CMD_CLR_EN, 10'd5, 8'd0);
    send_word(CMD_CLR_PEND, 10'd63, 8'd0);
    send_word(CMD_EOI, 10'd20, 8'd0);
    send_word(CMD_EOI, 10'd63, 8'd0);
    send_word(CMD_EOI, 10'd1023, 8'd0);
    send_word(CMD_SET_PEND, 10'd64, 8'hFF);
    send_word(4'd15, 10'd0, 8'hAA);
    send_word(CMD_LINE, 10'd63, 8'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_reg(CFG_PRIORITY_MASK, 8'h80);
        2: write_reg(CFG_PRIORITY_MASK, 8'h00);
        3: begin
          write_reg(CFG_PRIORITY_MASK, $urandom_range(1, 255));
          write_reg(CFG_DIST_ENABLE, 8'd0);
        end
        4: begin
          write_reg(CFG_DIST_ENABLE, 8'd1);
          write_reg(CFG_CPU_ENABLE, 8'd0);
        end
        5: begin
          write_reg(CFG_CPU_ENABLE, 8'd1);
          write_reg(CFG_PRIORITY_MASK, 8'hFF);
        end
        default: ;
      endcase
      for (int k = 0; k < 320; k++) begin
        quiet = (ph == 0 && k >= 100 && k < 200);
        if (ph == 1 && k == 50) hold_left = 600;
        if (ph == 5 && k == 160) begin
          in_ch.valid = 0;
          while (sb.expected.size() != 0) @(negedge clk);
        end
        random_word();
      end
      quiet = 0;
      drain();
    end

    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
